// File: rtl/min_jerk_trajectory_gen_unit_macros.svh
// Assertion macros for the minimum-jerk setpoint generator.
// Stand-alone header: no package or module dependencies.
`ifndef MIN_JERK_TRAJECTORY_GEN_UNIT_MACROS_SVH
`define MIN_JERK_TRAJECTORY_GEN_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MJT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mjt assertion failed");
// next-cycle implication
`define MJT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mjt assertion failed");
`else
`define MJT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define MJT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/mjt_pkg.sv
// Shared types, constants and the divider step for the minimum-jerk generator.
// No dependencies.
`timescale 1ns / 1ps
package mjt_pkg;

   localparam int MAX_JOINTS      = 2;
   localparam int JOINT_COUNT_DEF = 2;
   localparam int ANGLE_W         = 18;
   localparam int TIME_W          = 16;
   localparam int Q_FRAC          = 30;
   localparam int CSR_IDX_W       = 4;
   localparam int REG_COUNT       = 8;
   localparam int QUEUE_DEPTH     = 2;
   localparam int DIV_STEPS       = 2;
   localparam int DVD_W           = 32;
   localparam int CNT_W           = 4;
   localparam int POLY_W          = 33;
   localparam int PROD_W          = ANGLE_W + POLY_W;

   localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};
   localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W-1){1'b0}}};

   // register field within one joint's block of four
   typedef enum logic [1:0] {
      FLD_START = 2'd0,
      FLD_SPAN  = 2'd1,
      FLD_TIME  = 2'd2,
      FLD_GOAL  = 2'd3
   } cfg_field_type;

   typedef struct packed {
      logic                       wr;
      cfg_field_type              field;
      logic signed [ANGLE_W-1:0]  data;
   } csr_wr_type;

   // word held in the queue between front and back
   typedef struct packed {
      logic [TIME_W-1:0]     elapsed;
      logic [MAX_JOINTS-1:0] arrived;
   } job_type;

   typedef enum logic [3:0] {
      LN_IDLE,
      LN_DIVU,
      LN_POWR,
      LN_POLY,
      LN_PROD,
      LN_SCALE,
      LN_MAG,
      LN_DIVR,
      LN_DONE
   } lane_state_type;

   // one restoring division step; remainder stays below the divisor
   function automatic logic [TIME_W:0] div_step(input logic [TIME_W-1:0] rem,
                                                input logic              bit_in,
                                                input logic [TIME_W-1:0] divisor);
      logic [TIME_W:0] sh;
      sh = {rem, bit_in};
      if (sh >= {1'b0, divisor}) begin
         return {TIME_W'(sh - {1'b0, divisor}), 1'b1};
      end
      return {sh[TIME_W-1:0], 1'b0};
   endfunction

endpackage

// File: rtl/mjt_front.sv
// Front end: accepts tick words, flags arrived joints and queues them.
// Depends on mjt_pkg.
`timescale 1ns / 1ps
module mjt_front (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic [mjt_pkg::TIME_W-1:0]                 req_elapsed_ms,
   input  logic [mjt_pkg::MAX_JOINTS-1:0][mjt_pkg::TIME_W-1:0] move_time,
   output logic                                       job_valid,
   output mjt_pkg::job_type                           job,
   input  logic                                       job_pop
);
   localparam int PTR_W = (mjt_pkg::QUEUE_DEPTH > 1) ? $clog2(mjt_pkg::QUEUE_DEPTH) : 1;

   mjt_pkg::job_type            slot_ff [mjt_pkg::QUEUE_DEPTH];
   mjt_pkg::job_type            new_job;
   logic [PTR_W-1:0]            wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]              count_ff, count_in;
   logic                        push;

   // classify: a joint has arrived once elapsed reaches its duration
   always_comb begin
      new_job.elapsed = req_elapsed_ms;
      for (int j = 0; j < mjt_pkg::MAX_JOINTS; j++) begin
         new_job.arrived[j] = (req_elapsed_ms >= move_time[j]);
      end
   end

   assign req_ready = (count_ff != (PTR_W+1)'(mjt_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign job_valid = (count_ff != '0);
   assign job       = slot_ff[rd_ptr_ff];

   // queue pointers
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(mjt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (job_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(mjt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !job_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && job_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

// File: rtl/mjt_lane.sv
// Back-end lane: one joint's registers and its quintic setpoint/rate engine.
// Depends on mjt_pkg (types, constants, div_step).
`timescale 1ns / 1ps
module mjt_lane (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mjt_pkg::csr_wr_type                  csr,
   output logic [mjt_pkg::TIME_W-1:0]           move_time,
   input  logic                                 start,
   input  logic [mjt_pkg::TIME_W-1:0]           elapsed,
   input  logic                                 arrived,
   input  logic                                 take,
   output logic                                 idle,
   output logic                                 done,
   output logic signed [mjt_pkg::ANGLE_W-1:0]   setpoint,
   output logic signed [mjt_pkg::ANGLE_W-1:0]   rate,
   output logic                                 arrived_out
);
   localparam int TW  = mjt_pkg::TIME_W;
   localparam int AW  = mjt_pkg::ANGLE_W;
   localparam int QF  = mjt_pkg::Q_FRAC;
   localparam int PW  = mjt_pkg::POLY_W;
   localparam int XW  = PW + 4;
   localparam int MW  = mjt_pkg::PROD_W;
   localparam int RW  = MW + 11;
   localparam int DW  = mjt_pkg::DVD_W;
   localparam int CW  = mjt_pkg::CNT_W;
   localparam logic [CW-1:0] U_LAST = CW'(QF / mjt_pkg::DIV_STEPS - 1);
   localparam logic [CW-1:0] R_LAST = CW'(DW / mjt_pkg::DIV_STEPS - 1);
   localparam logic [CW-1:0] P_LAST = CW'(3);

   // configuration registers
   logic signed [AW-1:0] start_ang_ff, span_ff, goal_ff;
   logic [TW-1:0]        time_ff;

   mjt_pkg::lane_state_type state_ff, state_in;
   logic [CW-1:0]        cnt_ff, cnt_in;

   logic [TW-1:0]        rem_ff, rem_a;
   logic [DW-1:0]        dvd_ff, dvd_a, quo_ff, quo_a;
   logic [QF-1:0]        u_ff, p2_ff, p3_ff, p4_ff, p5_ff, mul_src;
   logic [2*QF-1:0]      mul_full;
   logic signed [XW-1:0] s_x, r_x;
   logic signed [PW-1:0] s_ff, r_ff;
   logic signed [MW-1:0] ps_ff, pr_ff;
   logic [MW-1:0]        pos_mag, absr_ff;
   logic [MW-1:0]        pos_rnd;
   logic signed [AW+4:0] pos_off, pos_sum;
   logic                 rneg_ff;
   logic [RW-1:0]        rate_num;
   logic signed [AW-1:0] setpoint_ff, rate_ff, pos_sat, rate_sat;
   logic                 arrived_ff;

   assign move_time   = time_ff;
   assign idle        = (state_ff == mjt_pkg::LN_IDLE);
   assign done        = (state_ff == mjt_pkg::LN_DONE);
   assign setpoint    = setpoint_ff;
   assign rate        = rate_ff;
   assign arrived_out = arrived_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ang_ff <= '0;
         span_ff      <= '0;
         time_ff      <= '0;
         goal_ff      <= '0;
      end else if (csr.wr) begin
         unique case (csr.field)
            mjt_pkg::FLD_START: start_ang_ff <= csr.data;
            mjt_pkg::FLD_SPAN:  span_ff      <= csr.data;
            mjt_pkg::FLD_TIME:  time_ff      <= csr.data[TW-1:0];
            mjt_pkg::FLD_GOAL:  goal_ff      <= csr.data;
            default:            goal_ff      <= goal_ff;
         endcase
      end
   end

   // shared divider: two restoring steps a cycle; zeros shift in for t/T
   always_comb begin
      logic [TW:0] st;
      logic        bin;
      rem_a = rem_ff;
      quo_a = quo_ff;
      dvd_a = dvd_ff;
      for (int k = 0; k < mjt_pkg::DIV_STEPS; k++) begin
         bin   = (state_ff == mjt_pkg::LN_DIVR) ? dvd_a[DW-1] : 1'b0;
         st    = mjt_pkg::div_step(rem_a, bin, time_ff);
         rem_a = st[TW:1];
         quo_a = {quo_a[DW-2:0], st[0]};
         dvd_a = {dvd_a[DW-2:0], 1'b0};
      end
   end

   // shared multiplier for the powers of u
   always_comb begin
      case (cnt_ff[1:0])
         2'd0:    mul_src = u_ff;
         2'd1:    mul_src = p2_ff;
         2'd2:    mul_src = p3_ff;
         default: mul_src = p4_ff;
      endcase
   end
   assign mul_full = mul_src * u_ff;

   // polynomial weights in Q30
   assign s_x = $signed({4'b0, PW'(p3_ff)}) * XW'(10) - $signed({4'b0, PW'(p4_ff)}) * XW'(15)
              + $signed({4'b0, PW'(p5_ff)}) * XW'(6);
   assign r_x = $signed({4'b0, PW'(p2_ff)}) * XW'(30) - $signed({4'b0, PW'(p3_ff)}) * XW'(60)
              + $signed({4'b0, PW'(p4_ff)}) * XW'(30);

   // setpoint: round half away from zero, add start, saturate
   always_comb begin
      pos_mag = ps_ff[MW-1] ? MW'(-ps_ff) : MW'(ps_ff);
      pos_rnd = pos_mag + (MW'(1) << (QF - 1));
      pos_off = ps_ff[MW-1] ? -$signed({1'b0, (AW+4)'(pos_rnd[MW-1:QF])})
                            :  $signed({1'b0, (AW+4)'(pos_rnd[MW-1:QF])});
      pos_sum = (AW+5)'(start_ang_ff) + pos_off;
      if (pos_sum > (AW+5)'(mjt_pkg::ANGLE_MAX)) begin
         pos_sat = mjt_pkg::ANGLE_MAX;
      end else if (pos_sum < (AW+5)'(mjt_pkg::ANGLE_MIN)) begin
         pos_sat = mjt_pkg::ANGLE_MIN;
      end else begin
         pos_sat = pos_sum[AW-1:0];
      end
   end

   // rate numerator: |span*r|*1000 plus half of T<<30, then >>30 goes to the divider
   assign rate_num = RW'(absr_ff) * RW'(1000) + (RW'(time_ff) << (QF - 1));

   // rate: sign and saturate the divider quotient
   always_comb begin
      if (!rneg_ff) begin
         rate_sat = (quo_a > DW'(mjt_pkg::ANGLE_MAX)) ? mjt_pkg::ANGLE_MAX : quo_a[AW-1:0];
      end else begin
         rate_sat = (quo_a > DW'(1 << (AW - 1))) ? mjt_pkg::ANGLE_MIN : AW'(-quo_a);
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         mjt_pkg::LN_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = arrived ? mjt_pkg::LN_DONE : mjt_pkg::LN_DIVU;
            end
         end
         mjt_pkg::LN_DIVU: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == U_LAST) begin
               cnt_in   = '0;
               state_in = mjt_pkg::LN_POWR;
            end
         end
         mjt_pkg::LN_POWR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == P_LAST) begin
               cnt_in   = '0;
               state_in = mjt_pkg::LN_POLY;
            end
         end
         mjt_pkg::LN_POLY:  state_in = mjt_pkg::LN_PROD;
         mjt_pkg::LN_PROD:  state_in = mjt_pkg::LN_SCALE;
         mjt_pkg::LN_SCALE: state_in = mjt_pkg::LN_MAG;
         mjt_pkg::LN_MAG: begin
            cnt_in   = '0;
            state_in = mjt_pkg::LN_DIVR;
         end
         mjt_pkg::LN_DIVR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == R_LAST) begin
               cnt_in   = '0;
               state_in = mjt_pkg::LN_DONE;
            end
         end
         mjt_pkg::LN_DONE: begin
            if (take) begin
               state_in = mjt_pkg::LN_IDLE;
            end
         end
         default: state_in = mjt_pkg::LN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mjt_pkg::LN_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         mjt_pkg::LN_IDLE: begin
            rem_ff      <= elapsed;
            quo_ff      <= '0;
            dvd_ff      <= '0;
            setpoint_ff <= goal_ff;
            rate_ff     <= '0;
            arrived_ff  <= arrived;
         end
         mjt_pkg::LN_DIVU: begin
            rem_ff <= rem_a;
            quo_ff <= quo_a;
            u_ff   <= quo_a[QF-1:0];
         end
         mjt_pkg::LN_POWR: begin
            case (cnt_ff[1:0])
               2'd0:    p2_ff <= mul_full[2*QF-1:QF];
               2'd1:    p3_ff <= mul_full[2*QF-1:QF];
               2'd2:    p4_ff <= mul_full[2*QF-1:QF];
               default: p5_ff <= mul_full[2*QF-1:QF];
            endcase
         end
         mjt_pkg::LN_POLY: begin
            s_ff <= s_x[PW-1:0];
            r_ff <= r_x[PW-1:0];
         end
         mjt_pkg::LN_PROD: begin
            ps_ff <= $signed(span_ff) * $signed(s_ff);
            pr_ff <= $signed(span_ff) * $signed(r_ff);
         end
         mjt_pkg::LN_SCALE: begin
            setpoint_ff <= pos_sat;
            absr_ff     <= pr_ff[MW-1] ? MW'(-pr_ff) : MW'(pr_ff);
            rneg_ff     <= pr_ff[MW-1];
         end
         mjt_pkg::LN_MAG: begin
            rem_ff <= '0;
            quo_ff <= '0;
            dvd_ff <= DW'(rate_num[RW-1:QF]);
         end
         mjt_pkg::LN_DIVR: begin
            rem_ff  <= rem_a;
            quo_ff  <= quo_a;
            dvd_ff  <= dvd_a;
            rate_ff <= rate_sat;
         end
         default: begin
            rem_ff <= rem_ff;
         end
      endcase
   end

endmodule

// File: rtl/min_jerk_trajectory_gen_unit.sv
// Minimum-jerk joint setpoint generator, top level: registers, front, lanes, output word.
// Depends on mjt_pkg, mjt_front, mjt_lane and the macros header.
// Ticks wait in the front queue while the lanes work; each lane's shared divider makes
// two quotient bits a cycle, first for t/T, then for the rate, and a lane whose joint has
// arrived skips it. Synchronous active-high reset clears the configuration registers and
// the result valid flag, empties the two-word queue and idles the lanes.
`timescale 1ns / 1ps
`include "min_jerk_trajectory_gen_unit_macros.svh"
module min_jerk_trajectory_gen_unit #(
   parameter int JOINT_COUNT = mjt_pkg::JOINT_COUNT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mjt_pkg::TIME_W-1:0]          req_elapsed_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [mjt_pkg::ANGLE_W-1:0]  rsp_setpoint_a,
   output logic signed [mjt_pkg::ANGLE_W-1:0]  rsp_rate_a,
   output logic                                rsp_arrived_a,
   output logic signed [mjt_pkg::ANGLE_W-1:0]  rsp_setpoint_b,
   output logic signed [mjt_pkg::ANGLE_W-1:0]  rsp_rate_b,
   output logic                                rsp_arrived_b,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mjt_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic signed [mjt_pkg::ANGLE_W-1:0]  csr_wdata
);
   localparam int NJ = mjt_pkg::MAX_JOINTS;
   localparam int AW = mjt_pkg::ANGLE_W;

   logic [NJ-1:0][mjt_pkg::TIME_W-1:0] lane_time;
   logic                 job_valid, job_pop, take, all_idle, all_done;
   mjt_pkg::job_type     job;
   logic [NJ-1:0]        lane_idle, lane_done, lane_arr;
   logic signed [AW-1:0] lane_set  [NJ];
   logic signed [AW-1:0] lane_rate [NJ];
   logic                 rsp_valid_ff;
   logic signed [AW-1:0] out_set_ff  [NJ];
   logic signed [AW-1:0] out_rate_ff [NJ];
   logic [NJ-1:0]        out_arr_ff;

   assign csr_ready = 1'b1;

   mjt_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_elapsed_ms (req_elapsed_ms),
      .move_time      (lane_time),
      .job_valid      (job_valid),
      .job            (job),
      .job_pop        (job_pop)
   );

   // lanes start together and hand over together
   assign all_idle = &lane_idle;
   assign all_done = &lane_done;
   assign job_pop  = job_valid && all_idle;
   assign take     = all_done && (!rsp_valid_ff || rsp_ready);

   for (genvar j = 0; j < NJ; j++) begin : g_lane
      if (j < JOINT_COUNT) begin : g_used
         mjt_pkg::csr_wr_type csr_wr;
         always_comb begin
            csr_wr.wr    = csr_valid && (csr_index < mjt_pkg::CSR_IDX_W'(mjt_pkg::REG_COUNT))
                           && (csr_index[2] == 1'(j));
            csr_wr.field = mjt_pkg::cfg_field_type'(csr_index[1:0]);
            csr_wr.data  = csr_wdata;
         end
         mjt_lane u_lane (
            .clock       (clock),
            .reset       (reset),
            .csr         (csr_wr),
            .move_time   (lane_time[j]),
            .start       (job_pop),
            .elapsed     (job.elapsed),
            .arrived     (job.arrived[j]),
            .take        (take),
            .idle        (lane_idle[j]),
            .done        (lane_done[j]),
            .setpoint    (lane_set[j]),
            .rate        (lane_rate[j]),
            .arrived_out (lane_arr[j])
         );
      end else begin : g_unused
         // joint not fitted: fixed zero result
         assign lane_time[j] = '0;
         assign lane_idle[j] = 1'b1;
         assign lane_done[j] = 1'b1;
         assign lane_set[j]  = '0;
         assign lane_rate[j] = '0;
         assign lane_arr[j]  = 1'b0;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         for (int j = 0; j < NJ; j++) begin
            out_set_ff[j]  <= lane_set[j];
            out_rate_ff[j] <= lane_rate[j];
            out_arr_ff[j]  <= lane_arr[j];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_setpoint_a = out_set_ff[0];
   assign rsp_rate_a     = out_rate_ff[0];
   assign rsp_arrived_a  = out_arr_ff[0];
   assign rsp_setpoint_b = out_set_ff[1];
   assign rsp_rate_b     = out_rate_ff[1];
   assign rsp_arrived_b  = out_arr_ff[1];

   // an arrived joint never carries a rate
   `MJT_ASSERT_IMPL(a_arr_rate_a, clock, reset, rsp_valid && rsp_arrived_a, rsp_rate_a == '0)
   `MJT_ASSERT_IMPL(a_arr_rate_b, clock, reset, rsp_valid && rsp_arrived_b, rsp_rate_b == '0)
   // a handover always leaves a result word pending
   `MJT_ASSERT_NEXT(a_take_valid, clock, reset, take, rsp_valid && !(lane_done[0] && all_idle))
   // unfitted joint B stays at zero
   `MJT_ASSERT_IMPL(a_unused_b, clock, reset, (JOINT_COUNT < 2) && rsp_valid, !rsp_arrived_b && rsp_setpoint_b == '0)

endmodule
